// ===== src/skt_pkg.sv =====
// shared types and codes for the sorted key table unit
// request and result structs, entry layout, controller states
// no dependencies
package skt_pkg;

  localparam int KEY_BITS         = 32;
  localparam int HANDLE_BITS      = 32;
  localparam int KIND_BITS        = 2;
  localparam int COUNT_OUT_BITS   = 10;
  localparam int CAPACITY_DEFAULT = 512;

  localparam logic [1:0] REQ_FIND   = 2'd0;
  localparam logic [1:0] REQ_INSERT = 2'd1;
  localparam logic [1:0] REQ_ERASE  = 2'd2;

  localparam logic [1:0] STS_DONE    = 2'd0;
  localparam logic [1:0] STS_ABSENT  = 2'd1;
  localparam logic [1:0] STS_PRESENT = 2'd2;
  localparam logic [1:0] STS_FULL    = 2'd3;

  typedef struct packed {
    logic [1:0]             req_type;
    logic [KEY_BITS-1:0]    key;
    logic [KIND_BITS-1:0]   entry_kind;
    logic [HANDLE_BITS-1:0] entry_handle;
  } skt_req_t;

  typedef struct packed {
    logic [1:0]                status;
    logic [KIND_BITS-1:0]      found_kind;
    logic [HANDLE_BITS-1:0]    found_handle;
    logic [COUNT_OUT_BITS-1:0] entry_count;
  } skt_res_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]    key;
    logic [KIND_BITS-1:0]   kind;
    logic [HANDLE_BITS-1:0] handle;
  } skt_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRCH,
    ST_CMP,
    ST_CHECK,
    ST_ACT,
    ST_SHIFT
  } skt_state_t;

endpackage

// ===== src/sorted_key_table_unit.sv =====
// sorted key table: entries held in key order in one synchronous memory
// binary search, then shifts entries up or down one per cycle for insert and erase
// depends on skt_pkg
//
// A request is taken when start is high and busy is low; busy stays high until its result
// has been produced. Each request gives exactly one result, shown for one cycle with
// out_valid high; the receiver cannot stall it, so it must take every strobe. Each halving step
// of the search is a memory read, then a compare; then, if the slot found holds an entry, it is
// read and its key checked. An insert or erase that succeeds then moves each later entry once,
// one per cycle through the single write port, then drains the last write and finishes. An unused
// request code is answered with done in the cycle after it is taken. The memory has no reset;
// only entries below the current count are ever read.
module sorted_key_table_unit #(
  parameter int CAPACITY = skt_pkg::CAPACITY_DEFAULT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  skt_pkg::skt_req_t in_req,
  output logic              out_valid,
  output skt_pkg::skt_res_t out_res
);
  import skt_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE     = CW'(1);

  skt_entry_t mem [CAPACITY];
  skt_entry_t rdata_r;

  skt_state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt;
  logic [CW-1:0] src_r, src_nxt, dst_r, dst_nxt, rem_r, rem_nxt;
  logic          pend_r, pend_nxt, up_r, up_nxt, hit_r, hit_nxt;
  skt_req_t      req_r, req_nxt;
  skt_entry_t    found_r, found_nxt;
  logic          out_valid_r, out_valid_nxt;
  skt_res_t      out_res_r, out_res_nxt;

  logic          ren, wen;
  logic [AW-1:0] raddr, waddr;
  skt_entry_t    wdata;
  logic [CW-1:0] mid_calc;

  assign mid_calc = lo_r + ((hi_r - lo_r) >> 1);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    src_nxt       = src_r;
    dst_nxt       = dst_r;
    rem_nxt       = rem_r;
    pend_nxt      = 1'b0;
    up_nxt        = up_r;
    hit_nxt       = hit_r;
    req_nxt       = req_r;
    found_nxt     = found_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = out_res_r;
    ren           = 1'b0;
    wen           = 1'b0;
    raddr         = mid_calc[AW-1:0];
    waddr         = dst_r[AW-1:0];
    wdata         = rdata_r;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          req_nxt = in_req;
          lo_nxt  = '0;
          hi_nxt  = count_r;
          if (in_req.req_type == REQ_FIND || in_req.req_type == REQ_INSERT ||
              in_req.req_type == REQ_ERASE) begin
            state_nxt = ST_SRCH;
          end else begin
            // unused code: answer at once, table untouched
            out_valid_nxt = 1'b1;
            out_res_nxt   = '{STS_DONE, '0, '0, COUNT_OUT_BITS'(count_r)};
          end
        end
      end
      ST_SRCH: begin
        if (lo_r < hi_r) begin
          ren       = 1'b1;
          raddr     = mid_calc[AW-1:0];
          mid_nxt   = mid_calc;
          state_nxt = ST_CMP;
        end else if (lo_r < count_r) begin
          ren       = 1'b1;
          raddr     = lo_r[AW-1:0];
          state_nxt = ST_CHECK;
        end else begin
          hit_nxt   = 1'b0;
          state_nxt = ST_ACT;
        end
      end
      ST_CMP: begin
        if (rdata_r.key < req_r.key) begin
          lo_nxt = mid_r + ONE;
        end else begin
          hi_nxt = mid_r;
        end
        state_nxt = ST_SRCH;
      end
      ST_CHECK: begin
        hit_nxt   = (rdata_r.key == req_r.key);
        found_nxt = rdata_r;
        state_nxt = ST_ACT;
      end
      ST_ACT: begin
        state_nxt = ST_IDLE;
        case (req_r.req_type)
          REQ_FIND: begin
            out_valid_nxt = 1'b1;
            if (hit_r) begin
              out_res_nxt = '{STS_DONE, found_r.kind, found_r.handle,
                              COUNT_OUT_BITS'(count_r)};
            end else begin
              out_res_nxt = '{STS_ABSENT, '0, '0, COUNT_OUT_BITS'(count_r)};
            end
          end
          REQ_INSERT: begin
            if (hit_r) begin
              out_valid_nxt = 1'b1;
              out_res_nxt   = '{STS_PRESENT, '0, '0, COUNT_OUT_BITS'(count_r)};
            end else if (count_r >= CAP_CNT) begin
              out_valid_nxt = 1'b1;
              out_res_nxt   = '{STS_FULL, '0, '0, COUNT_OUT_BITS'(count_r)};
            end else begin
              // move entries from the top down so nothing is overwritten before it is read
              up_nxt    = 1'b1;
              src_nxt   = count_r - ONE;
              rem_nxt   = count_r - lo_r;
              state_nxt = ST_SHIFT;
            end
          end
          REQ_ERASE: begin
            if (!hit_r) begin
              out_valid_nxt = 1'b1;
              out_res_nxt   = '{STS_ABSENT, '0, '0, COUNT_OUT_BITS'(count_r)};
            end else begin
              up_nxt    = 1'b0;
              src_nxt   = lo_r + ONE;
              rem_nxt   = count_r - lo_r - ONE;
              state_nxt = ST_SHIFT;
            end
          end
          default: begin
            out_valid_nxt = 1'b1;
            out_res_nxt   = '{STS_DONE, '0, '0, COUNT_OUT_BITS'(count_r)};
          end
        endcase
      end
      ST_SHIFT: begin
        // write back the entry read last cycle while reading the next one
        if (pend_r) begin
          wen   = 1'b1;
          waddr = dst_r[AW-1:0];
          wdata = rdata_r;
        end
        if (rem_r != '0) begin
          ren      = 1'b1;
          raddr    = src_r[AW-1:0];
          pend_nxt = 1'b1;
          dst_nxt  = up_r ? (src_r + ONE) : (src_r - ONE);
          src_nxt  = up_r ? (src_r - ONE) : (src_r + ONE);
          rem_nxt  = rem_r - ONE;
        end else if (!pend_r) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          if (up_r) begin
            wen       = 1'b1;
            waddr     = lo_r[AW-1:0];
            wdata     = '{req_r.key, req_r.entry_kind, req_r.entry_handle};
            count_nxt = count_r + ONE;
          end else begin
            count_nxt = count_r - ONE;
          end
          out_res_nxt = '{STS_DONE, '0, '0, COUNT_OUT_BITS'(count_nxt)};
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    mid_r     <= mid_nxt;
    src_r     <= src_nxt;
    dst_r     <= dst_nxt;
    rem_r     <= rem_nxt;
    up_r      <= up_nxt;
    hit_r     <= hit_nxt;
    req_r     <= req_nxt;
    found_r   <= found_nxt;
    out_res_r <= out_res_nxt;
  end

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ren) begin
      rdata_r <= mem[raddr];
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // a searching request never answers in the very next cycle
  a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_req.req_type == REQ_FIND || in_req.req_type == REQ_INSERT ||
                        in_req.req_type == REQ_ERASE)) |=> (busy && !out_valid))
    else $error("request entered search but block went idle");

  // moving entries must never read and write the same slot together
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (wen && ren) |-> (waddr != raddr))
    else $error("shift read and write hit the same entry");

  // draining the last move finishes the request with a result next cycle
  a_shift_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SHIFT && rem_r == '0 && !pend_r) |=> (out_valid && !busy))
    else $error("shift finished without a result");

  // the entry count never passes the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r <= CAP_CNT))
    else $error("entry count beyond capacity");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// self-checking bench for sorted_key_table_unit: directed table, then random find/insert/erase
// traffic (with unused codes) that fills the table to capacity; results checked against typed
// results or an in-bench copy of the table; depends on skt_pkg and sorted_key_table_unit
module tb;
  import skt_pkg::*;

  localparam int          TABLE_DEPTH = CAPACITY_DEFAULT;
  localparam logic [1:0]  REQ_SPARE   = 2'd3;
  localparam int          STALL_LIMIT = 4000;
  localparam int          DRAIN       = 40;
  localparam int          MAX_REPORTS = 10;
  localparam int          DIR_ROWS    = 22;

  typedef struct {
    skt_req_t req;
    bit       typed;
    skt_res_t res;
  } dir_row_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  skt_req_t in_req = '0;
  logic     busy;
  logic     out_valid;
  skt_res_t out_res;

  // bench copy of the table
  skt_entry_t  tbl_entries [TABLE_DEPTH];
  int unsigned tbl_count = 0;

  skt_res_t    result_q [$];
  int unsigned n_mismatch = 0;
  int unsigned stall_cycles = 0;
  bit          idle_on = 1'b1;
  int unsigned n_find = 0, n_insert = 0, n_erase = 0, n_spare = 0;
  int unsigned n_full = 0, n_dup = 0, n_absent = 0, peak_count = 0;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{'{REQ_FIND,   32'h0000_0000, 2'd0, 32'h0000_0000}, 1'b1, '{STS_ABSENT, 2'd0, 32'h0, 10'd0}},
    '{'{REQ_ERASE,  32'hFFFF_FFFF, 2'd3, 32'hFFFF_FFFF}, 1'b1, '{STS_ABSENT, 2'd0, 32'h0, 10'd0}},
    '{'{REQ_SPARE,  32'h1234_5678, 2'd1, 32'h0BAD_F00D}, 1'b1, '{STS_DONE, 2'd0, 32'h0, 10'd0}},
    '{'{REQ_INSERT, 32'h0000_0000, 2'd0, 32'h0000_0000}, 1'b1, '{STS_DONE, 2'd0, 32'h0, 10'd1}},
    '{'{REQ_INSERT, 32'hFFFF_FFFF, 2'd3, 32'hFFFF_FFFF}, 1'b1, '{STS_DONE, 2'd0, 32'h0, 10'd2}},
    '{'{REQ_FIND,   32'hFFFF_FFFF, 2'd0, 32'h0000_0000}, 1'b1,
      '{STS_DONE, 2'd3, 32'hFFFF_FFFF, 10'd2}},
    '{'{REQ_FIND,   32'h0000_0000, 2'd2, 32'h5555_5555}, 1'b1, '{STS_DONE, 2'd0, 32'h0, 10'd2}},
    '{'{REQ_INSERT, 32'h0000_0000, 2'd3, 32'h0000_1234}, 1'b1, '{STS_PRESENT, 2'd0, 32'h0, 10'd2}},
    '{'{REQ_INSERT, 32'h8000_0000, 2'd1, 32'hA5A5_A5A5}, 1'b0, '0},
    '{'{REQ_INSERT, 32'h7FFF_FFFF, 2'd2, 32'h5A5A_5A5A}, 1'b0, '0},
    '{'{REQ_FIND,   32'h8000_0000, 2'd0, 32'h0000_0000}, 1'b0, '0},
    '{'{REQ_FIND,   32'h8000_0001, 2'd0, 32'h0000_0000}, 1'b1, '{STS_ABSENT, 2'd0, 32'h0, 10'd4}},
    '{'{REQ_SPARE,  32'h7FFF_FFFF, 2'd2, 32'hFFFF_0000}, 1'b0, '0},
    '{'{REQ_ERASE,  32'h0000_0000, 2'd0, 32'h0000_0000}, 1'b0, '0},
    '{'{REQ_FIND,   32'h7FFF_FFFF, 2'd0, 32'h0000_0000}, 1'b0, '0},
    '{'{REQ_ERASE,  32'hFFFF_FFFF, 2'd0, 32'h0000_0000}, 1'b0, '0},
    '{'{REQ_ERASE,  32'h8000_0000, 2'd1, 32'h0000_FFFF}, 1'b0, '0},
    '{'{REQ_FIND,   32'h0000_0000, 2'd0, 32'h0000_0000}, 1'b1, '{STS_ABSENT, 2'd0, 32'h0, 10'd1}},
    '{'{REQ_INSERT, 32'h0000_0001, 2'd1, 32'h0000_0000}, 1'b0, '0},
    '{'{REQ_ERASE,  32'h7FFF_FFFF, 2'd0, 32'h0000_0000}, 1'b0, '0},
    '{'{REQ_FIND,   32'h0000_0001, 2'd3, 32'hFFFF_FFFF}, 1'b0, '0},
    '{'{REQ_ERASE,  32'h0000_0002, 2'd0, 32'h0000_0000}, 1'b0, '0}
  };

  sorted_key_table_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // lowest slot whose key is not below k
  function automatic int unsigned key_slot(logic [KEY_BITS-1:0] k);
    int unsigned lo, hi, mid;
    lo = 0;
    hi = tbl_count;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (tbl_entries[mid].key < k) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic skt_res_t apply_request(skt_req_t r);
    skt_res_t    res;
    int unsigned pos;
    int unsigned i;
    bit          hit;
    res = '0;
    res.status = STS_DONE;
    pos = key_slot(r.key);
    hit = (pos < tbl_count) && (tbl_entries[pos].key == r.key);
    case (r.req_type)
      REQ_FIND: begin
        if (hit) begin
          res.found_kind   = tbl_entries[pos].kind;
          res.found_handle = tbl_entries[pos].handle;
        end else begin
          res.status = STS_ABSENT;
        end
      end
      REQ_INSERT: begin
        // a duplicate key wins over the full check
        if (hit) begin
          res.status = STS_PRESENT;
        end else if (tbl_count >= TABLE_DEPTH) begin
          res.status = STS_FULL;
        end else begin
          for (i = tbl_count; i > pos; i--) tbl_entries[i] = tbl_entries[i-1];
          tbl_entries[pos] = '{r.key, r.entry_kind, r.entry_handle};
          tbl_count++;
        end
      end
      REQ_ERASE: begin
        if (!hit) begin
          res.status = STS_ABSENT;
        end else begin
          for (i = pos; i + 1 < tbl_count; i++) tbl_entries[i] = tbl_entries[i+1];
          tbl_count--;
        end
      end
      default: ;
    endcase
    res.entry_count = COUNT_OUT_BITS'(tbl_count);
    return res;
  endfunction

  // a held key (or a neighbour) p_known percent of the time, some extremes, the rest anywhere
  function automatic logic [KEY_BITS-1:0] pick_key(int unsigned p_known);
    int unsigned         roll;
    logic [KEY_BITS-1:0] k;
    roll = $urandom_range(99);
    if (tbl_count != 0 && roll < p_known) begin
      k = tbl_entries[$urandom_range(tbl_count - 1)].key;
      if ($urandom_range(4) == 0) k = $urandom_range(1) ? k + 1'b1 : k - 1'b1;
    end else if (roll >= 95) begin
      k = $urandom_range(1) ? '0 : '1;
    end else begin
      k = KEY_BITS'($urandom);
    end
    return k;
  endfunction

  function automatic skt_req_t rand_req(int unsigned w_find, int unsigned w_ins,
                                        int unsigned w_era, int unsigned p_known);
    skt_req_t    r;
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < w_find) r.req_type = REQ_FIND;
    else if (roll < w_find + w_ins) r.req_type = REQ_INSERT;
    else if (roll < w_find + w_ins + w_era) r.req_type = REQ_ERASE;
    else r.req_type = REQ_SPARE;
    r.key          = pick_key(p_known);
    r.entry_kind   = KIND_BITS'($urandom_range(3));
    r.entry_handle = HANDLE_BITS'($urandom);
    return r;
  endfunction

  // called at a rising edge; returns at the edge where the request is taken
  task automatic issue(input skt_req_t r, input bit typed, input skt_res_t typed_res);
    skt_res_t pred;
    if (idle_on && $urandom_range(99) < 28) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    start  <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (!(start && !busy));
    pred = apply_request(r);
    result_q.push_back(typed ? typed_res : pred);
    case (r.req_type)
      REQ_FIND:   n_find++;
      REQ_INSERT: n_insert++;
      REQ_ERASE:  n_erase++;
      default:    n_spare++;
    endcase
    if (pred.status == STS_FULL) n_full++;
    if (pred.status == STS_PRESENT) n_dup++;
    if (pred.status == STS_ABSENT) n_absent++;
    if (tbl_count > peak_count) peak_count = tbl_count;
  endtask

  task automatic wait_results;
    start <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
  endtask

  // result checker: the block cannot be stalled, so every strobe is taken
  always @(posedge clk) begin
    skt_res_t want;
    if (rst_n && out_valid) begin
      if (result_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= MAX_REPORTS)
          $display("unexpected result: sts=%0d kind=%0d hdl=%08h cnt=%0d",
                   out_res.status, out_res.found_kind, out_res.found_handle,
                   out_res.entry_count);
      end else begin
        want = result_q.pop_front();
        if (out_res.status !== want.status || out_res.found_kind !== want.found_kind ||
            out_res.found_handle !== want.found_handle ||
            out_res.entry_count !== want.entry_count) begin
          n_mismatch++;
          if (n_mismatch <= MAX_REPORTS)
            $display("mismatch sts/kind/hdl/cnt: exp %0d/%0d/%08h/%0d got %0d/%0d/%08h/%0d",
                     want.status, want.found_kind, want.found_handle, want.entry_count,
                     out_res.status, out_res.found_kind, out_res.found_handle,
                     out_res.entry_count);
        end
      end
    end
  end

  // watchdog on cycles with neither a request nor a result moving
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("timeout: no progress for %0d cycles", STALL_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int unsigned i;
    int unsigned leftovers;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < DIR_ROWS; i++) issue(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);

    // mixed traffic on a small table
    for (i = 0; i < 40; i++) issue(rand_req(30, 35, 30, 60), 1'b0, '0);
    wait_results();

    // grow to capacity, the first stretch back to back
    i = 0;
    while (tbl_count < TABLE_DEPTH) begin
      idle_on = (i >= 150);
      issue(rand_req(1, 98, 1, 0), 1'b0, '0);
      i++;
    end
    idle_on = 1'b1;

    // around the full mark: new keys refused, duplicates reported, erase and refill
    for (i = 0; i < 30; i++) issue(rand_req(20, 60, 15, 40), 1'b0, '0);

    // erase heavy, long downward shifts
    for (i = 0; i < 30; i++) issue(rand_req(15, 10, 70, 80), 1'b0, '0);

    wait_results();
    repeat (DRAIN) @(posedge clk);
    leftovers = result_q.size();

    $display("requests: %0d find, %0d insert, %0d erase, %0d unused code; peak count %0d",
             n_find, n_insert, n_erase, n_spare, peak_count);
    $display("outcomes: %0d absent, %0d duplicate, %0d refused as full; %0d mismatches",
             n_absent, n_dup, n_full, n_mismatch);
    if (n_mismatch == 0 && leftovers == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
